// ===== hw/rtl/fdt_pkg.sv =====
package fdt_pkg;

   // Character codes used by the text sequencer.
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_POINT = 8'h2E;
   localparam logic [7:0] CHAR_SPACE = 8'h20;

   // Precision values above this one are treated as this one.
   localparam logic [3:0] LIMIT_MAX = 4'd14;

   // Number of digit and separator characters allowed ahead of the prefix.
   localparam logic [3:0] TEXT_MAX = 4'd13;

   // Per-transaction formatting controls handed from the front end to the sequencer.
   typedef struct packed {
      logic       full;    // precision 0: keep later separators and pad before the prefix
      logic [3:0] budget;  // characters allowed from the decimal point onward
   } job_type;

   typedef enum logic [4:0] {
      EMIT_IDLE   = 5'b00001,
      EMIT_FIND   = 5'b00010,
      EMIT_TEXT   = 5'b00100,
      EMIT_SPACE  = 5'b01000,
      EMIT_PREFIX = 5'b10000
   } emit_state_type;

   // A group separator follows the digit of weight 10^k for these k.
   function automatic logic is_sep(input logic [4:0] k);
      is_sep = (k == 5'd3) || (k == 5'd6) || (k == 5'd9) || (k == 5'd12) || (k == 5'd15);
   endfunction

   // Number of separators for a value whose leading digit has weight 10^top.
   function automatic logic [2:0] groups_of(input logic [4:0] top);
      logic [2:0] g;
      g = 3'd0;
      if (top >= 5'd3)  g = 3'd1;
      if (top >= 5'd6)  g = 3'd2;
      if (top >= 5'd9)  g = 3'd3;
      if (top >= 5'd12) g = 3'd4;
      if (top >= 5'd15) g = 3'd5;
      groups_of = g;
   endfunction

   function automatic logic [7:0] prefix_char(input logic [2:0] groups);
      logic [7:0] c;
      case (groups)
         3'd0:    c = CHAR_SPACE;
         3'd1:    c = 8'h6B;  // k
         3'd2:    c = 8'h4D;  // M
         3'd3:    c = 8'h47;  // G
         3'd4:    c = 8'h54;  // T
         default: c = 8'h50;  // P
      endcase
      prefix_char = c;
   endfunction

endpackage

// ===== hw/rtl/fdt_dabble.sv =====
module fdt_dabble #(
   parameter int VALUE_BITS = 32,
   parameter int DIGITS_MAX = 10
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [VALUE_BITS-1:0]     value,
   output logic                      done,
   output logic [DIGITS_MAX*4-1:0]   bcd
);

   localparam int CNT_W = $clog2(VALUE_BITS);
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(VALUE_BITS - 1);

   logic                    busy_ff, busy_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]   bin_ff, bin_in;
   logic [DIGITS_MAX*4-1:0] bcd_ff, bcd_in;
   logic [DIGITS_MAX*4-1:0] adjusted;

   // Shift-and-add-3: every digit of 5 or more is corrected before the next shift.
   always_comb begin
      for (int i = 0; i < DIGITS_MAX; i++) begin
         if (bcd_ff[i*4 +: 4] >= 4'd5) begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4] + 4'd3;
         end else begin
            adjusted[i*4 +: 4] = bcd_ff[i*4 +: 4];
         end
      end
   end

   assign done = busy_ff && (cnt_ff == CNT_LAST);
   assign bcd  = bcd_ff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         bin_in  = value;
         bcd_in  = '0;
      end else if (busy_ff) begin
         bin_in = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in = {adjusted[DIGITS_MAX*4-2:0], bin_ff[VALUE_BITS-1]};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

endmodule

// ===== hw/rtl/fdt_emit.sv =====
module fdt_emit #(
   parameter int DIGITS_MAX = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  fdt_pkg::job_type        job,
   input  logic [DIGITS_MAX*4-1:0] bcd,
   output logic                    finish,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [7:0]              rsp_text_char,
   output logic                    rsp_last_char
);

   localparam int IDX_W = $clog2(DIGITS_MAX);

   fdt_pkg::emit_state_type state_ff, state_in, end_state;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             at_sep_ff, at_sep_in;
   logic             point_pending_ff, point_pending_in;
   logic [3:0]       budget_ff, budget_in;
   logic [3:0]       n_ff, n_in;
   logic [2:0]       groups_ff, groups_in;

   logic             out_valid_ff, out_valid_in;
   logic [7:0]       out_char_ff, out_char_in;
   logic             out_last_ff, out_last_in;

   logic             can_push;
   logic [3:0]       digit;
   logic [IDX_W-1:0] top;
   logic [7:0]       ch;
   logic             counted;
   logic             skip;
   logic             stop;

   assign can_push      = !out_valid_ff || rsp_ready;
   assign digit         = bcd[idx_ff*4 +: 4];
   assign rsp_valid     = out_valid_ff;
   assign rsp_text_char = out_char_ff;
   assign rsp_last_char = out_last_ff;

   // Leading nonzero digit; a zero value still shows one digit.
   always_comb begin
      top = '0;
      for (int i = 0; i < DIGITS_MAX; i++) begin
         if (bcd[i*4 +: 4] != 4'd0) begin
            top = IDX_W'(i);
         end
      end
   end

   assign end_state = (job.full && (groups_ff != 3'd0)) ? fdt_pkg::EMIT_SPACE
                                                        : fdt_pkg::EMIT_PREFIX;

   // Character at the current position and whether it is counted against the precision.
   always_comb begin
      ch      = fdt_pkg::CHAR_SPACE;
      counted = 1'b0;
      skip    = 1'b0;
      if (!at_sep_ff) begin
         ch      = fdt_pkg::CHAR_ZERO + {4'd0, digit};
         counted = !point_pending_ff;
      end else if (point_pending_ff) begin
         ch      = fdt_pkg::CHAR_POINT;
         counted = 1'b1;
      end else if (job.full) begin
         ch      = fdt_pkg::CHAR_SPACE;
         counted = 1'b1;
      end else begin
         skip = 1'b1;
      end
      stop = !skip && ((counted && (budget_ff == 4'd0)) || (n_ff >= fdt_pkg::TEXT_MAX));
   end

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      at_sep_in        = at_sep_ff;
      point_pending_in = point_pending_ff;
      budget_in        = budget_ff;
      n_in             = n_ff;
      groups_in        = groups_ff;
      out_valid_in     = out_valid_ff && !rsp_ready;
      out_char_in      = out_char_ff;
      out_last_in      = out_last_ff;
      finish           = 1'b0;

      unique case (state_ff)
         fdt_pkg::EMIT_IDLE: begin
            if (start) begin
               state_in = fdt_pkg::EMIT_FIND;
            end
         end
         fdt_pkg::EMIT_FIND: begin
            idx_in           = top;
            groups_in        = fdt_pkg::groups_of(5'(top));
            at_sep_in        = 1'b0;
            point_pending_in = 1'b1;
            budget_in        = job.budget;
            n_in             = 4'd0;
            state_in         = fdt_pkg::EMIT_TEXT;
         end
         fdt_pkg::EMIT_TEXT: begin
            if (can_push) begin
               if (stop) begin
                  state_in = end_state;
               end else if (skip) begin
                  at_sep_in = 1'b0;
                  idx_in    = idx_ff - IDX_W'(1);
               end else begin
                  out_valid_in = 1'b1;
                  out_char_in  = ch;
                  out_last_in  = 1'b0;
                  n_in         = n_ff + 4'd1;
                  if (counted) begin
                     budget_in = budget_ff - 4'd1;
                  end
                  if (at_sep_ff) begin
                     point_pending_in = 1'b0;
                     at_sep_in        = 1'b0;
                     idx_in           = idx_ff - IDX_W'(1);
                  end else if (fdt_pkg::is_sep(5'(idx_ff))) begin
                     at_sep_in = 1'b1;
                  end else if (idx_ff == '0) begin
                     state_in = end_state;
                  end else begin
                     idx_in = idx_ff - IDX_W'(1);
                  end
               end
            end
         end
         fdt_pkg::EMIT_SPACE: begin
            if (can_push) begin
               out_valid_in = 1'b1;
               out_char_in  = fdt_pkg::CHAR_SPACE;
               out_last_in  = 1'b0;
               state_in     = fdt_pkg::EMIT_PREFIX;
            end
         end
         fdt_pkg::EMIT_PREFIX: begin
            if (can_push) begin
               out_valid_in = 1'b1;
               out_char_in  = fdt_pkg::prefix_char(groups_ff);
               out_last_in  = 1'b1;
               finish       = 1'b1;
               state_in     = fdt_pkg::EMIT_IDLE;
            end
         end
         default: begin
            state_in = fdt_pkg::EMIT_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fdt_pkg::EMIT_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      idx_ff           <= idx_in;
      at_sep_ff        <= at_sep_in;
      point_pending_ff <= point_pending_in;
      budget_ff        <= budget_in;
      n_ff             <= n_in;
      groups_ff        <= groups_in;
      out_char_ff      <= out_char_in;
      out_last_ff      <= out_last_in;
   end

endmodule

// ===== hw/rtl/frequency_to_decimal_text_si_prefix_unit.sv =====
// The first character appears once the bit-serial binary-to-BCD converter has finished
// and the character sequencer has found the leading digit; the converter sets most of
// the time a transaction takes. Characters then leave one at a time, held while rsp_ready
// is low; the output register can load a new one as the consumer takes the last.
// Reset is synchronous and active high; it returns both sequencers and the output to idle.
// The request side is not ready again until the prefix character has been loaded.
module frequency_to_decimal_text_si_prefix_unit #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [VALUE_BITS-1:0] req_frequency,
   input  logic [3:0]            req_digits_limit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [7:0]            rsp_text_char,
   output logic                  rsp_last_char
);

   // Decimal digits needed for the widest value (log10(2) scaled by 10^5).
   localparam int DIGITS_MAX = (VALUE_BITS * 30103) / 100000 + 1;

   logic                    busy_ff, busy_in;
   fdt_pkg::job_type        job_ff, job_in;
   logic                    accept;
   logic                    conv_done;
   logic                    finish;
   logic [DIGITS_MAX*4-1:0] bcd;

   // A transaction is held from acceptance until its prefix character has been
   // loaded into the output register, so only one value is in flight.
   assign req_ready = !busy_ff;
   assign accept    = req_valid && req_ready;

   // The precision is turned into a character budget counted from the decimal
   // point onward. Precision 0 selects the full form with the maximum budget,
   // and anything above the maximum precision is clamped to it.
   always_comb begin
      job_in = job_ff;
      if (accept) begin
         job_in.full = (req_digits_limit == 4'd0);
         if ((req_digits_limit == 4'd0) || (req_digits_limit > fdt_pkg::LIMIT_MAX)) begin
            job_in.budget = fdt_pkg::LIMIT_MAX + 4'd1;
         end else begin
            job_in.budget = req_digits_limit + 4'd1;
         end
      end
   end

   always_comb begin
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      job_ff <= job_in;
   end

   // Binary to BCD, one input bit per cycle through the add-3 and shift unit.
   fdt_dabble #(
      .VALUE_BITS (VALUE_BITS),
      .DIGITS_MAX (DIGITS_MAX)
   ) u_dabble (
      .clock (clock),
      .reset (reset),
      .start (accept),
      .value (req_frequency),
      .done  (conv_done),
      .bcd   (bcd)
   );

   // Character sequencer: walks the digits from the most significant one, places
   // the decimal point and separators, applies the precision and appends the prefix.
   fdt_emit #(
      .DIGITS_MAX (DIGITS_MAX)
   ) u_emit (
      .clock         (clock),
      .reset         (reset),
      .start         (conv_done),
      .job           (job_ff),
      .bcd           (bcd),
      .finish        (finish),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_text_char (rsp_text_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule
